>>> rtl/awba_pkg.sv
// Shared types and constants for the area-weighted box aggregation block.
// No dependencies; compiled first.
`default_nettype none

package awba_pkg;

    localparam int ACC_W     = 48;
    localparam int AREA_W    = 24;
    localparam int ENTRY_W   = ACC_W + 2 * AREA_W;
    localparam int TOT_W     = AREA_W + 1;
    localparam int QUO_W     = ACC_W + TOT_W;
    localparam int ROW_W     = 16;
    localparam int COL_W     = 12;
    localparam int K_W       = 5;
    localparam int KOFF_W    = 4;
    localparam int GCOL_W    = 13;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;
    localparam logic [AREA_W-1:0]       AREA_SAT = 24'hFF_FFFF;

    typedef enum logic [1:0] {METH_AVG, METH_MIN, METH_MAX, METH_SUM} method_t;

    typedef enum logic [1:0] {
        REG_BOX_SIZE, REG_METHOD, REG_GRID_COLS, REG_GRID_ROWS
    } reg_index_t;

    typedef struct packed {
        logic [K_W-1:0]    box_size;
        method_t           method;
        logic [GCOL_W-1:0] grid_cols;
        logic [ROW_W-1:0]  grid_rows;
    } cfg_t;

    // Classification of one cell, made by the front end.
    typedef struct packed {
        logic             first;
        logic             box_end;
        logic             frame_end;
        logic [COL_W-1:0] bc;
        logic [ROW_W-1:0] br;
    } item_ctl_t;

    typedef enum logic [1:0] {BK_IDLE, BK_UPD, BK_DIV, BK_OUT} back_state_t;

    typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_DIV, DV_DONE} div_state_t;

endpackage

`default_nettype wire

>>> rtl/awba_if.sv
// Valid/ready channel interfaces for cells in and boxes out.
// Depends on awba_pkg for the fixed field widths.
`default_nettype none

interface awba_cell_if #(parameter int VALUE_BITS = 24, parameter int AREA_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] cell_value;
    logic                         cell_valid;
    logic [AREA_BITS-1:0]         cell_area;

    modport source (output valid, cell_value, cell_valid, cell_area, input ready);
    modport sink   (input valid, cell_value, cell_valid, cell_area, output ready);
endinterface

interface awba_box_if;
    import awba_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        box_row;
    logic [COL_W-1:0]        box_col;
    logic signed [ACC_W-1:0] box_result;
    logic                    box_missing;
    logic                    frame_end;

    modport source (output valid, box_row, box_col, box_result, box_missing, frame_end,
                    input ready);
    modport sink   (input valid, box_row, box_col, box_result, box_missing, frame_end,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/awba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module awba_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/awba_fifo.sv
// Short request queue between the front end and the back end.
// No dependencies.
`default_nettype none

module awba_fifo #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/awba_div.sv
// Iterative scale-and-divide unit: |acc| * tot / valid_area, saturated.
// Shift-add multiply, then restoring division one bit a cycle. Uses awba_pkg.
`default_nettype none

module awba_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           mul_en,
    input  wire logic                           neg,
    input  wire logic [awba_pkg::ACC_W-1:0]     mag,
    input  wire logic [awba_pkg::TOT_W-1:0]     tot,
    input  wire logic [awba_pkg::AREA_W-1:0]    divisor,
    output logic                                done,
    output logic signed [awba_pkg::ACC_W-1:0]   result
);
    import awba_pkg::*;

    div_state_t           state_reg, state_next;
    logic [QUO_W-1:0]     p_reg;
    logic [TOT_W-1:0]     t_reg;
    logic [AREA_W-1:0]    d_reg, r_reg;
    logic [ACC_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [6:0]           cnt_reg;

    logic [QUO_W-1:0]     p_mul;
    logic [AREA_W:0]      rs;
    logic                 ge;
    logic [AREA_W-1:0]    r_div;
    logic                 big;

    assign p_mul = {p_reg[QUO_W-2:0], 1'b0} + (t_reg[TOT_W-1] ? QUO_W'(mag_reg) : '0);
    assign rs    = {r_reg, p_reg[QUO_W-1]};
    assign ge    = (rs >= {1'b0, d_reg});
    assign r_div = ge ? AREA_W'(rs - {1'b0, d_reg}) : rs[AREA_W-1:0];
    assign big   = |p_reg[QUO_W-1:ACC_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    p_reg   <= mul_en ? '0 : QUO_W'(mag);
                    t_reg   <= tot;
                    d_reg   <= divisor;
                    r_reg   <= '0;
                    mag_reg <= mag;
                    neg_reg <= neg;
                    cnt_reg <= mul_en ? 7'(TOT_W - 1) : 7'(QUO_W - 1);
                end
            end
            DV_MUL:
            begin
                p_reg   <= p_mul;
                t_reg   <= {t_reg[TOT_W-2:0], 1'b0};
                cnt_reg <= (cnt_reg == '0) ? 7'(QUO_W - 1) : cnt_reg - 1'b1;
            end
            DV_DIV:
            begin
                p_reg   <= {p_reg[QUO_W-2:0], ge};
                r_reg   <= r_div;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        if (neg_reg)
        begin
            result = big ? ACC_MIN : -$signed(p_reg[ACC_W-1:0]);
        end
        else
        begin
            result = big ? ACC_MAX : $signed(p_reg[ACC_W-1:0]);
        end
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = mul_en ? DV_MUL : DV_DIV;
                end
            end
            DV_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DV_DIV;
                end
            end
            DV_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                done       = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/awba_front.sv
// Front end: raster position counters and per-cell classification.
// Re-derives box position by serial division on a box size write. Uses awba_pkg.
`default_nettype none

module awba_front #(
    parameter int MAX_COLS   = 4096,
    parameter int VALUE_BITS = 24,
    parameter int AREA_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    awba_cell_if.sink                  cells,
    input  wire awba_pkg::cfg_t        cfg,
    input  wire logic                  resync,
    input  wire logic                  full,
    output logic                       push,
    output awba_pkg::item_ctl_t        push_ctl
);
    import awba_pkg::*;

    localparam logic [16:0] MAXC = 17'(MAX_COLS);

    logic [COL_W-1:0]  col_reg, bc_reg;
    logic [ROW_W-1:0]  row_reg, br_reg;
    logic [KOFF_W-1:0] cib_reg, rib_reg;
    logic              busy_reg;
    logic [3:0]        cnt_reg;
    logic [15:0]       dc_reg, dr_reg;
    logic [KOFF_W-1:0] rc_reg, rr_reg;

    logic [K_W-1:0]    k;
    logic [KOFF_W-1:0] kmax;
    logic [16:0]       cols_eff;
    logic [ROW_W-1:0]  rows_eff;
    logic              last_col, last_row, cib_end, rib_end;
    logic [K_W-1:0]    rsc, rsr;
    logic              qc, qr;
    logic [KOFF_W-1:0] rcn, rrn;
    logic [15:0]       dcn, drn;

    always_comb
    begin
        if (cfg.box_size == '0)
        begin
            k = K_W'(1);
        end
        else if (cfg.box_size > K_W'(16))
        begin
            k = K_W'(16);
        end
        else
        begin
            k = cfg.box_size;
        end
        kmax     = KOFF_W'(k - 1'b1);
        cols_eff = (cfg.grid_cols == '0) ? 17'd1 : 17'(cfg.grid_cols);
        if (cols_eff > MAXC)
        begin
            cols_eff = MAXC;
        end
        rows_eff = (cfg.grid_rows == '0) ? 16'd1 : cfg.grid_rows;
    end

    assign last_col = (17'(col_reg) >= cols_eff - 17'd1);
    assign last_row = (row_reg >= rows_eff - 16'd1);
    assign cib_end  = (cib_reg == kmax);
    assign rib_end  = (rib_reg == kmax);

    assign cells.ready = !full && !busy_reg && !resync;
    assign push        = cells.valid && cells.ready;

    assign push_ctl.first     = (cib_reg == '0) && (rib_reg == '0);
    assign push_ctl.box_end   = (cib_end || last_col) && (rib_end || last_row);
    assign push_ctl.frame_end = last_col && last_row;
    assign push_ctl.bc        = bc_reg;
    assign push_ctl.br        = br_reg;

    // one restoring-division step for column and row in parallel
    assign rsc = {rc_reg, dc_reg[15]};
    assign rsr = {rr_reg, dr_reg[15]};
    assign qc  = (rsc >= k);
    assign qr  = (rsr >= k);
    assign rcn = qc ? KOFF_W'(rsc - k) : rsc[KOFF_W-1:0];
    assign rrn = qr ? KOFF_W'(rsr - k) : rsr[KOFF_W-1:0];
    assign dcn = {dc_reg[14:0], qc};
    assign drn = {dr_reg[14:0], qr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            bc_reg   <= '0;
            br_reg   <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            dc_reg   <= '0;
            dr_reg   <= '0;
            rc_reg   <= '0;
            rr_reg   <= '0;
        end
        else if (resync)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            dc_reg   <= 16'(col_reg);
            dr_reg   <= row_reg;
            rc_reg   <= '0;
            rr_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dc_reg  <= dcn;
            dr_reg  <= drn;
            rc_reg  <= rcn;
            rr_reg  <= rrn;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 4'd15)
            begin
                busy_reg <= 1'b0;
                bc_reg   <= dcn[COL_W-1:0];
                br_reg   <= drn;
                cib_reg  <= rcn;
                rib_reg  <= rrn;
            end
        end
        else if (push)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                cib_reg <= '0;
                bc_reg  <= '0;
                if (last_row)
                begin
                    row_reg <= '0;
                    rib_reg <= '0;
                    br_reg  <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    rib_reg <= rib_end ? '0 : rib_reg + 1'b1;
                    br_reg  <= rib_end ? br_reg + 1'b1 : br_reg;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                cib_reg <= cib_end ? '0 : cib_reg + 1'b1;
                bc_reg  <= cib_end ? bc_reg + 1'b1 : bc_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/awba_back.sv
// Back end: read-modify-write of the per-column box store, result formation.
// Instantiates awba_ram and awba_div; uses awba_pkg and awba_box_if.
`default_nettype none

module awba_back #(
    parameter int MAX_COLS   = 4096,
    parameter int VALUE_BITS = 24,
    parameter int AREA_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire awba_pkg::method_t     method,
    input  wire logic [$bits(awba_pkg::item_ctl_t)+VALUE_BITS+AREA_BITS:0] head,
    input  wire logic                  empty,
    output logic                       pop,
    awba_box_if.source                 boxes
);
    import awba_pkg::*;

    localparam int IDX_W  = $clog2(MAX_COLS);
    localparam int PROD_W = VALUE_BITS + AREA_BITS + 1;

    back_state_t                  state_reg, state_next;
    item_ctl_t                    ctl_reg;
    logic                         cvalid_reg;
    logic [AREA_BITS-1:0]         area_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [ACC_W-1:0]      prod_reg;
    logic [IDX_W-1:0]             addr_reg;
    logic signed [ACC_W-1:0]      res_reg;
    logic                         miss_reg;
    logic                         ovld_reg;
    logic [ROW_W-1:0]             orow_reg;
    logic [COL_W-1:0]             ocol_reg;
    logic signed [ACC_W-1:0]      ores_reg;
    logic                         omiss_reg;
    logic                         oend_reg;

    item_ctl_t                    h_ctl;
    logic signed [VALUE_BITS-1:0] h_value;
    logic                         h_valid;
    logic [AREA_BITS-1:0]         h_area;
    logic [16:0]                  h_bc;
    logic [IDX_W-1:0]             h_idx;
    logic signed [PROD_W-1:0]     h_prod;
    logic signed [63:0]           h_prod_ext;

    logic [ENTRY_W-1:0]           rd_data, wr_data;
    logic signed [ACC_W-1:0]      init_acc, base_acc, new_acc, val48;
    logic [AREA_W-1:0]            base_v, base_m, new_v, new_m;
    logic [AREA_W:0]              vsum, msum;
    logic                         neg, need_div, div_start, div_done, load;
    logic [ACC_W-1:0]             mag;
    logic [TOT_W-1:0]             tot;
    logic signed [ACC_W-1:0]      div_res;

    assign {h_ctl, h_value, h_valid, h_area} = head;
    assign h_bc       = 17'(h_ctl.bc);
    assign h_idx      = (h_bc >= 17'(MAX_COLS)) ? IDX_W'(MAX_COLS - 1) : IDX_W'(h_bc);
    assign h_prod     = h_value * $signed({1'b0, h_area});
    assign h_prod_ext = 64'(h_prod);

    awba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_COLS)) u_ram (
        .clk   (clk),
        .we    (state_reg == BK_UPD),
        .waddr (addr_reg),
        .wdata (wr_data),
        .re    (pop),
        .raddr (h_idx),
        .rdata (rd_data)
    );

    // entry update
    always_comb
    begin
        case (method)
            METH_MIN: init_acc = ACC_MAX;
            METH_MAX: init_acc = ACC_MIN;
            default:  init_acc = '0;
        endcase
        base_acc = ctl_reg.first ? init_acc : $signed(rd_data[ENTRY_W-1:2*AREA_W]);
        base_v   = ctl_reg.first ? '0 : rd_data[2*AREA_W-1:AREA_W];
        base_m   = ctl_reg.first ? '0 : rd_data[AREA_W-1:0];
        vsum     = {1'b0, base_v} + TOT_W'(area_reg);
        msum     = {1'b0, base_m} + TOT_W'(area_reg);
        val48    = ACC_W'(value_reg);
        new_acc  = base_acc;
        new_v    = base_v;
        new_m    = base_m;
        if (cvalid_reg)
        begin
            new_v = vsum[AREA_W] ? AREA_SAT : vsum[AREA_W-1:0];
            case (method)
                METH_MIN: new_acc = (val48 < base_acc) ? val48 : base_acc;
                METH_MAX: new_acc = (val48 > base_acc) ? val48 : base_acc;
                default:  new_acc = base_acc + prod_reg;
            endcase
        end
        else
        begin
            new_m = msum[AREA_W] ? AREA_SAT : msum[AREA_W-1:0];
        end
        wr_data  = {new_acc, new_v, new_m};
        neg      = new_acc[ACC_W-1];
        mag      = neg ? ACC_W'(-new_acc) : ACC_W'(new_acc);
        tot      = (method == METH_SUM) ? ({1'b0, new_v} + {1'b0, new_m}) : TOT_W'(1);
        need_div = (new_v != '0) && ((method == METH_AVG) || (method == METH_SUM));
    end

    awba_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mul_en  (method == METH_SUM),
        .neg     (neg),
        .mag     (mag),
        .tot     (tot),
        .divisor (new_v),
        .done    (div_done),
        .result  (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        load       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_UPD;
                end
            end
            BK_UPD:
            begin
                if (!ctl_reg.box_end)
                begin
                    state_next = BK_IDLE;
                end
                else if (need_div)
                begin
                    div_start  = 1'b1;
                    state_next = BK_DIV;
                end
                else
                begin
                    state_next = BK_OUT;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!ovld_reg || boxes.ready)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                ovld_reg <= 1'b1;
            end
            else if (boxes.ready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ctl_reg    <= h_ctl;
            cvalid_reg <= h_valid;
            area_reg   <= h_area;
            value_reg  <= h_value;
            prod_reg   <= h_prod_ext[ACC_W-1:0];
            addr_reg   <= h_idx;
        end
        if (state_reg == BK_UPD)
        begin
            res_reg  <= (new_v == '0) ? '0 : new_acc;
            miss_reg <= (new_v == '0);
        end
        if ((state_reg == BK_DIV) && div_done)
        begin
            res_reg <= div_res;
        end
        if (load)
        begin
            orow_reg  <= ctl_reg.br;
            ocol_reg  <= ctl_reg.bc;
            ores_reg  <= res_reg;
            omiss_reg <= miss_reg;
            oend_reg  <= ctl_reg.frame_end;
        end
    end

    assign boxes.valid       = ovld_reg;
    assign boxes.box_row     = orow_reg;
    assign boxes.box_col     = ocol_reg;
    assign boxes.box_result  = ores_reg;
    assign boxes.box_missing = omiss_reg;
    assign boxes.frame_end   = oend_reg;

endmodule

`default_nettype wire

>>> rtl/area_weighted_box_aggregation.sv
// Area-weighted box aggregation: top level, configuration registers and queue.
// Depends on awba_pkg, awba_if, awba_front, awba_fifo, awba_back.
// The back end takes a new cell only after the store read and write-back of
// the last one, and at a box end only after its result is loaded; min/max
// and missing boxes skip the divide unit, and sum multiplies before dividing.
// Reset: counters and queue cleared, config to defaults; the column store is
// not cleared, each box's first cell initialises its entry.
`default_nettype none

module area_weighted_box_aggregation #(
    parameter int MAX_COLS   = 4096,
    parameter int VALUE_BITS = 24,
    parameter int AREA_BITS  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    awba_cell_if.sink                                cells,
    awba_box_if.source                               boxes,
    input  wire logic                                cfg_wr_en,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [awba_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import awba_pkg::*;

    // queue word: classification, value, valid flag, area
    localparam int FW = $bits(item_ctl_t) + VALUE_BITS + 1 + AREA_BITS;

    cfg_t      cfg_reg;
    logic      resync_reg;
    logic      push, pop, full, empty;
    item_ctl_t push_ctl;
    logic [FW-1:0] q_head;

    // Configuration registers; a box size write triggers a re-derivation of
    // the in-box position in the front end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_size  <= K_W'(2);
            cfg_reg.method    <= METH_AVG;
            cfg_reg.grid_cols <= GCOL_W'(4096);
            cfg_reg.grid_rows <= ROW_W'(65535);
            resync_reg        <= 1'b0;
        end
        else
        begin
            resync_reg <= cfg_wr_en && (reg_index_t'(cfg_index) == REG_BOX_SIZE);
            if (cfg_wr_en)
            begin
                case (reg_index_t'(cfg_index))
                    REG_BOX_SIZE:  cfg_reg.box_size  <= cfg_data[K_W-1:0];
                    REG_METHOD:    cfg_reg.method    <= method_t'(cfg_data[1:0]);
                    REG_GRID_COLS: cfg_reg.grid_cols <= cfg_data[GCOL_W-1:0];
                    REG_GRID_ROWS: cfg_reg.grid_rows <= cfg_data[ROW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // front end: takes a cell each cycle unless resyncing or queue is full
    awba_front #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .AREA_BITS  (AREA_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cells    (cells),
        .cfg      (cfg_reg),
        .resync   (resync_reg),
        .full     (full),
        .push     (push),
        .push_ctl (push_ctl)
    );

    awba_fifo #(.WIDTH(FW), .DEPTH(4)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({push_ctl, cells.cell_value, cells.cell_valid, cells.cell_area}),
        .pop   (pop),
        .rdata (q_head),
        .full  (full),
        .empty (empty)
    );

    // back end: store update, divide, output register
    awba_back #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .AREA_BITS  (AREA_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .method (cfg_reg.method),
        .head   (q_head),
        .empty  (empty),
        .pop    (pop),
        .boxes  (boxes)
    );

endmodule

`default_nettype wire
